// ===== rtl/segseq_pkg.sv =====
// shared types and constants for the seven-segment digit sequencer
// no dependencies
`timescale 1ns / 1ps

package segseq_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned FontW  = 40;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 1;

  // mode codes
  localparam logic [ModeW-1:0] ModeSleep  = 3'd0;
  localparam logic [ModeW-1:0] ModePlain  = 3'd1;
  localparam logic [ModeW-1:0] ModeChoose = 3'd2;
  localparam logic [ModeW-1:0] ModeMatch  = 3'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFontLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFontHigh = 1'b1;

  localparam logic [FontW-1:0] FontLowReset  = 40'h99B0A4F9C0;
  localparam logic [FontW-1:0] FontHighReset = 40'h9080F88292;

  localparam logic [ByteW-1:0] SelFirst  = 8'h08;
  localparam logic [ByteW-1:0] SelPrefix = 8'h01;
  localparam logic [ByteW-1:0] SelOff    = 8'h00;
  localparam logic [ByteW-1:0] PatDash   = 8'hBF;
  localparam logic [ByteW-1:0] PatBottom = 8'hF7;
  localparam logic [ByteW-1:0] PatPoint  = 8'h7F;
  localparam logic [ByteW-1:0] PatOff    = 8'hFF;

  // reciprocal of ten, exact for 16-bit values with a shift of 19
  localparam logic [ValueW-1:0] RecipTen   = 16'hCCCD;
  localparam int unsigned       RecipShift = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DASH,
    ST_PREFIX,
    ST_DIGIT,
    ST_CLOSE
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_DASH,
    EMIT_PREFIX,
    EMIT_DIGIT,
    EMIT_CLOSE
  } emit_e;

  typedef struct packed {
    logic  load;
    emit_e emit;
  } dp_cmd_t;

  typedef struct packed {
    logic             sel_one;
    logic             quot_zero;
  } dp_status_t;

endpackage

// ===== rtl/seven_segment_digit_sequencer.sv =====
// top level of the seven-segment digit sequencer
// depends on segseq_pkg, segseq_ctrl, segseq_dp
`timescale 1ns / 1ps

// Usage:
// An item (value_i, mode_i) is taken at a rising edge with start_i high and busy_o low.
// The block answers with a run of results, one per cycle, each shown for one cycle
// with out_valid_o high: digit_select_o, segment_pattern_o and last_o.
// The run ends with the all-off pair (select 0, pattern 0xFF) with last_o high.
// Run lengths: sleep 5, number modes 2 to 7, other modes 1.
// The first result passes the state and output registers; results follow
// back to back, one decimal digit per cycle from the divide-by-ten unit.
// busy_o drops in the cycle that shows the closing pair, so the next item can be
// taken then. The receiver cannot stall; results are not held.
// The font registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset loads the default font and returns the block to idle with no result pending.

module seven_segment_digit_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [segseq_pkg::ValueW-1:0]     value_i,
  input  logic [segseq_pkg::ModeW-1:0]      mode_i,
  input  logic                              cfg_we_i,
  input  logic [segseq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [segseq_pkg::FontW-1:0]      cfg_wdata_i,
  output logic                              out_valid_o,
  output logic [segseq_pkg::ByteW-1:0]      digit_select_o,
  output logic [segseq_pkg::ByteW-1:0]      segment_pattern_o,
  output logic                              last_o
);

  segseq_pkg::dp_cmd_t    cmd;
  segseq_pkg::dp_status_t status;

  segseq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  segseq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .value_i           (value_i),
    .mode_i            (mode_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .digit_select_o    (digit_select_o),
    .segment_pattern_o (segment_pattern_o),
    .last_o            (last_o)
  );

endmodule

// ===== rtl/segseq_ctrl.sv =====
// controller state machine of the digit sequencer
// depends on segseq_pkg
`timescale 1ns / 1ps

module segseq_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [segseq_pkg::ModeW-1:0]      mode_i,
  input  segseq_pkg::dp_status_t            status_i,
  output segseq_pkg::dp_cmd_t               cmd_o,
  output logic                              busy_o
);

  segseq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= segseq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = segseq_pkg::EMIT_NONE;
    unique case (state_q)
      segseq_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (mode_i) inside
            segseq_pkg::ModeSleep:  state_d = segseq_pkg::ST_DASH;
            segseq_pkg::ModePlain:  state_d = segseq_pkg::ST_DIGIT;
            segseq_pkg::ModeChoose,
            segseq_pkg::ModeMatch:  state_d = segseq_pkg::ST_PREFIX;
            default:                state_d = segseq_pkg::ST_CLOSE;
          endcase
        end
      end
      segseq_pkg::ST_DASH: begin
        cmd_o.emit = segseq_pkg::EMIT_DASH;
        if (status_i.sel_one) begin
          state_d = segseq_pkg::ST_CLOSE;
        end
      end
      segseq_pkg::ST_PREFIX: begin
        cmd_o.emit = segseq_pkg::EMIT_PREFIX;
        state_d    = segseq_pkg::ST_DIGIT;
      end
      segseq_pkg::ST_DIGIT: begin
        cmd_o.emit = segseq_pkg::EMIT_DIGIT;
        if (status_i.quot_zero) begin
          state_d = segseq_pkg::ST_CLOSE;
        end
      end
      segseq_pkg::ST_CLOSE: begin
        cmd_o.emit = segseq_pkg::EMIT_CLOSE;
        state_d    = segseq_pkg::ST_IDLE;
      end
      default: begin
        state_d = segseq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != segseq_pkg::ST_IDLE);

endmodule

// ===== rtl/segseq_dp.sv =====
// datapath: font registers, value and select registers, divide by ten, output register
// depends on segseq_pkg
`timescale 1ns / 1ps

module segseq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [segseq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [segseq_pkg::FontW-1:0]        cfg_wdata_i,
  input  logic [segseq_pkg::ValueW-1:0]       value_i,
  input  logic [segseq_pkg::ModeW-1:0]        mode_i,
  input  segseq_pkg::dp_cmd_t                 cmd_i,
  output segseq_pkg::dp_status_t              status_o,
  output logic                                out_valid_o,
  output logic [segseq_pkg::ByteW-1:0]        digit_select_o,
  output logic [segseq_pkg::ByteW-1:0]        segment_pattern_o,
  output logic                                last_o
);

  logic [segseq_pkg::FontW-1:0]    font_low_q, font_high_q;
  logic [segseq_pkg::ValueW-1:0]   value_q;
  logic [segseq_pkg::ModeW-1:0]    mode_q;
  logic [segseq_pkg::ByteW-1:0]    sel_q;
  logic                            out_valid_q;
  logic [segseq_pkg::ByteW-1:0]    sel_out_q, pat_out_q;
  logic                            last_q;

  logic [2*segseq_pkg::ValueW-1:0] prod;
  logic [segseq_pkg::ValueW-1:0]   quot;
  logic [segseq_pkg::ValueW-1:0]   quot_x10;
  logic [segseq_pkg::ValueW-1:0]   rem_full;
  logic [3:0]                      rem;
  logic [segseq_pkg::ByteW-1:0]    digit_pat;
  logic [segseq_pkg::ByteW-1:0]    prefix_pat;
  logic [segseq_pkg::ByteW-1:0]    sel_d, pat_d;
  logic                            last_d;

  // font registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_low_q  <= segseq_pkg::FontLowReset;
      font_high_q <= segseq_pkg::FontHighReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        segseq_pkg::RegFontLow:  font_low_q  <= cfg_wdata_i;
        segseq_pkg::RegFontHigh: font_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // divide by ten through the reciprocal
  assign prod     = value_q * segseq_pkg::RecipTen;
  assign quot     = {{segseq_pkg::RecipShift - segseq_pkg::ValueW{1'b0}},
                     prod[2*segseq_pkg::ValueW-1:segseq_pkg::RecipShift]};
  assign quot_x10 = {quot[segseq_pkg::ValueW-4:0], 3'b000}
                  + {quot[segseq_pkg::ValueW-2:0], 1'b0};
  assign rem_full = value_q - quot_x10;
  assign rem      = rem_full[3:0];

  always_comb begin
    case (rem)
      4'd0:    digit_pat = font_low_q[7:0];
      4'd1:    digit_pat = font_low_q[15:8];
      4'd2:    digit_pat = font_low_q[23:16];
      4'd3:    digit_pat = font_low_q[31:24];
      4'd4:    digit_pat = font_low_q[39:32];
      4'd5:    digit_pat = font_high_q[7:0];
      4'd6:    digit_pat = font_high_q[15:8];
      4'd7:    digit_pat = font_high_q[23:16];
      4'd8:    digit_pat = font_high_q[31:24];
      4'd9:    digit_pat = font_high_q[39:32];
      default: digit_pat = segseq_pkg::PatOff;
    endcase
  end

  assign prefix_pat = (mode_q == segseq_pkg::ModeChoose) ? segseq_pkg::PatBottom
                                                         : segseq_pkg::PatPoint;

  assign status_o.sel_one   = (sel_q == segseq_pkg::SelPrefix);
  assign status_o.quot_zero = (quot == '0);

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      mode_q  <= mode_i;
      sel_q   <= segseq_pkg::SelFirst;
    end else begin
      case (cmd_i.emit)
        segseq_pkg::EMIT_DASH: begin
          sel_q <= {1'b0, sel_q[segseq_pkg::ByteW-1:1]};
        end
        segseq_pkg::EMIT_DIGIT: begin
          sel_q   <= {1'b0, sel_q[segseq_pkg::ByteW-1:1]};
          value_q <= quot;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_d  = segseq_pkg::SelOff;
    pat_d  = segseq_pkg::PatOff;
    last_d = 1'b0;
    unique case (cmd_i.emit)
      segseq_pkg::EMIT_DASH: begin
        sel_d = sel_q;
        pat_d = segseq_pkg::PatDash;
      end
      segseq_pkg::EMIT_PREFIX: begin
        sel_d = segseq_pkg::SelPrefix;
        pat_d = prefix_pat;
      end
      segseq_pkg::EMIT_DIGIT: begin
        sel_d = sel_q;
        pat_d = digit_pat;
      end
      segseq_pkg::EMIT_CLOSE: begin
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (cmd_i.emit != segseq_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != segseq_pkg::EMIT_NONE) begin
      sel_out_q <= sel_d;
      pat_out_q <= pat_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign digit_select_o    = sel_out_q;
  assign segment_pattern_o = pat_out_q;
  assign last_o            = last_q;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for seven_segment_digit_sequencer: predicts the display run
// of every item and compares each result field by field; depends on segseq_pkg
`timescale 1ns / 1ps

module testbench;
  import segseq_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseItems   = 134;

  typedef struct packed {
    logic [ByteW-1:0] digit_select;
    logic [ByteW-1:0] segment_pattern;
    logic             last;
  } display_pair_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [ValueW-1:0]  value_in = '0;
  logic [ModeW-1:0]   mode_in = '0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [FontW-1:0]   cfg_wdata = '0;
  logic               out_valid;
  logic [ByteW-1:0]   digit_select;
  logic [ByteW-1:0]   segment_pattern;
  logic               last;

  logic [FontW-1:0] font_low = FontLowReset;
  logic [FontW-1:0] font_high = FontHighReset;
  display_pair_t    expected_pairs[$];
  int unsigned      sender_idle_pct = 0;
  int unsigned      cycle_count = 0;
  int unsigned      error_count = 0;

  seven_segment_digit_sequencer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .value_i          (value_in),
    .mode_i           (mode_in),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .out_valid_o      (out_valid),
    .digit_select_o   (digit_select),
    .segment_pattern_o(segment_pattern),
    .last_o           (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic display_pair_t pair_of(logic [ByteW-1:0] sel, logic [ByteW-1:0] pat,
                                            logic is_last);
    display_pair_t p;
    p.digit_select    = sel;
    p.segment_pattern = pat;
    p.last            = is_last;
    return p;
  endfunction

  // expected run of one item under the current font
  task automatic queue_display_run(logic [ValueW-1:0] value, logic [ModeW-1:0] mode);
    int unsigned      rest;
    int unsigned      d;
    logic [ByteW-1:0] sel;
    logic [ByteW-1:0] pat;
    rest = value;
    sel  = SelFirst;
    if (mode == ModeSleep) begin
      while (sel != SelOff) begin
        expected_pairs.push_back(pair_of(sel, PatDash, 1'b0));
        sel = sel >> 1;
      end
    end else if (mode <= ModeMatch) begin
      if (mode == ModeChoose) begin
        expected_pairs.push_back(pair_of(SelPrefix, PatBottom, 1'b0));
      end else if (mode == ModeMatch) begin
        expected_pairs.push_back(pair_of(SelPrefix, PatPoint, 1'b0));
      end
      do begin
        d   = rest % 10;
        pat = (d < 5) ? font_low[8*d +: 8] : font_high[8*(d-5) +: 8];
        expected_pairs.push_back(pair_of(sel, pat, 1'b0));
        sel  = sel >> 1;
        rest = rest / 10;
      end while (rest != 0);
    end
    expected_pairs.push_back(pair_of(SelOff, PatOff, 1'b1));
  endtask

  always @(posedge clk) begin
    display_pair_t want;
    if (rst_n && out_valid) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result sel %02h pat %02h last %0b", $time,
                 digit_select, segment_pattern, last);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (digit_select !== want.digit_select) begin
          $display("%0t: digit_select expected %02h actual %02h", $time,
                   want.digit_select, digit_select);
          error_count++;
        end
        if (segment_pattern !== want.segment_pattern) begin
          $display("%0t: segment_pattern expected %02h actual %02h", $time,
                   want.segment_pattern, segment_pattern);
          error_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last);
          error_count++;
        end
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_item(logic [ValueW-1:0] value, logic [ModeW-1:0] mode);
    int unsigned gap;
    bit          taken;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    value_in <= value;
    mode_in  <= mode;
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      if (taken) queue_display_run(value, mode);
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_font(logic [CfgIdxW-1:0] idx, logic [FontW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == RegFontLow) font_low = data;
    else font_high = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [FontW-1:0] random_font();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FontW-1:0];
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(3))
      0:       return ValueW'($urandom_range(99));
      1:       return ValueW'($urandom_range(65535, 10000));
      2:       return ValueW'($urandom_range(9999));
      default: return ValueW'($urandom);
    endcase
  endfunction

  task automatic test_reset_font();
    for (int m = 0; m < (1 << ModeW); m++) send_item(16'd0, ModeW'(m));
    send_item(16'd1, ModePlain);
    send_item(16'd9, ModePlain);
    send_item(16'd10, ModePlain);
    send_item(16'd99, ModeChoose);
    send_item(16'd9999, ModeMatch);
    send_item(16'd10000, ModePlain);
    send_item(16'd65535, ModePlain);
    send_item(16'd12345, ModeChoose);
    send_item(16'd57890, ModeMatch);
    send_item(16'd65535, ModeSleep);
    send_item(16'd65535, ModeW'(7));
    send_item(16'd40960, ModePlain);
    wait_drained();
  endtask

  task automatic test_font_extremes();
    write_font(RegFontLow, '0);
    write_font(RegFontHigh, '1);
    send_item(16'd1234, ModePlain);
    send_item(16'd56789, ModeChoose);
    send_item(16'd0, ModeMatch);
    wait_drained();
    write_font(RegFontLow, '1);
    write_font(RegFontHigh, '0);
    send_item(16'd43210, ModePlain);
    send_item(16'd58765, ModeMatch);
    send_item(16'd0, ModeChoose);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [ModeW-1:0] mode;
    int unsigned      pct[3] = '{24, 60, 0};
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = pct[phase];
      write_font(RegFontLow, random_font());
      write_font(RegFontHigh, random_font());
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(99) < 85) mode = ModeW'($urandom_range(3));
        else mode = ModeW'($urandom_range(7));
        send_item(random_value(), mode);
        if ($urandom_range(39) == 0) wait_drained();
      end
      wait_drained();
    end
    write_font(RegFontLow, FontLowReset);
    write_font(RegFontHigh, FontHighReset);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_font();
    test_font_extremes();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/segseq_pkg.sv
rtl/segseq_ctrl.sv
rtl/segseq_dp.sv
rtl/seven_segment_digit_sequencer.sv
tb/testbench.sv
